// File: src/address_range_translation_table_assert.svh
// Assertion macros for the range translation table.
// Both macros expect clk and arst_n in the scope where they are used.
`ifndef ADDRESS_RANGE_TRANSLATION_TABLE_ASSERT_SVH
`define ADDRESS_RANGE_TRANSLATION_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ARTTBL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ARTTBL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/arttbl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package arttbl_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int ADDR_W = 64;
	localparam int MODE_W = 2;
	localparam int STATUS_W = 3;
	localparam int COUNT_W = 7;

	// Request modes.
	typedef enum logic [MODE_W-1:0] {
		MODE_LOOKUP = 2'd0,
		MODE_SET    = 2'd1,
		MODE_CLEAR  = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK           = 3'd0,
		ST_NOT_FOUND    = 3'd1,
		ST_INVALID_SIZE = 3'd2,
		ST_CONFLICT     = 3'd3,
		ST_FULL         = 3'd4
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EVAL1,
		ST_EVAL2,
		ST_EVAL3,
		ST_EVAL4,
		ST_RESP
	} state_t;

	// Operations of the shared adder.
	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_ADDM1
	} alu_op_t;

	// One table entry as held in the entry memory.
	typedef struct packed {
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] len;
		logic [ADDR_W-1:0] tgt;
	} entry_t;

	// Outputs of the shared arithmetic and compare unit.
	typedef struct packed {
		logic [ADDR_W-1:0] sum;
		logic              eq;
		logic              lt;
		logic              lt2;
	} alu_res_t;

	// Control from the sequencer to the entry store.
	typedef struct packed {
		logic rd_en;
		logic mem_we;
		logic vld_set;
		logic vld_clr;
	} store_ctl_t;

	// Registered result of one request.
	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] trans;
		logic              exact;
	} result_t;

endpackage

`default_nettype wire

// File: src/arttbl_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface arttbl_req_if;
	import arttbl_pkg::*;

	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [ADDR_W-1:0] host_address;
	logic [ADDR_W-1:0] buffer_size;
	logic [ADDR_W-1:0] device_va;

	modport source (
		output valid, mode, host_address, buffer_size, device_va,
		input  ready
	);

	modport sink (
		input  valid, mode, host_address, buffer_size, device_va,
		output ready
	);
endinterface

`default_nettype wire

// File: src/arttbl_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface arttbl_rsp_if;
	import arttbl_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ADDR_W-1:0]   translated_address;
	logic                exact_key;
	logic [COUNT_W-1:0]  entry_count;

	modport source (
		output valid, status, translated_address, exact_key, entry_count,
		input  ready
	);

	modport sink (
		input  valid, status, translated_address, exact_key, entry_count,
		output ready
	);
endinterface

`default_nettype wire

// File: src/arttbl_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module arttbl_alu (
	input  arttbl_pkg::alu_op_t             op,
	input  wire [arttbl_pkg::ADDR_W-1:0]    add_a,
	input  wire [arttbl_pkg::ADDR_W-1:0]    add_b,
	input  wire [arttbl_pkg::ADDR_W-1:0]    cmp_a,
	input  wire [arttbl_pkg::ADDR_W-1:0]    cmp_b,
	input  wire [arttbl_pkg::ADDR_W-1:0]    cmp_c,
	input  wire [arttbl_pkg::ADDR_W-1:0]    cmp_d,
	output arttbl_pkg::alu_res_t            res
);
	import arttbl_pkg::*;

	// One 64-bit adder with three operations, modulo 2^64.
	always_comb begin
		unique case (op)
			ALU_ADD:   res.sum = add_a + add_b;
			ALU_SUB:   res.sum = add_a - add_b;
			ALU_ADDM1: res.sum = add_a + add_b - ADDR_W'(1);
			default:   res.sum = add_a + add_b;
		endcase
	end

	// Unsigned comparators: equality and order of a and b, order of c and d.
	assign res.eq  = (cmp_a == cmp_b);
	assign res.lt  = (cmp_a < cmp_b);
	assign res.lt2 = (cmp_c < cmp_d);
endmodule

`default_nettype wire

// File: src/arttbl_store.sv
`timescale 1ns / 1ps
`default_nettype none

module arttbl_store #(
	parameter int TABLE_ENTRIES = arttbl_pkg::TABLE_ENTRIES_DEF,
	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  arttbl_pkg::store_ctl_t  ctl,
	input  wire [IW-1:0]            rd_idx,
	input  wire [IW-1:0]            wr_idx,
	input  arttbl_pkg::entry_t      wr_entry,
	output arttbl_pkg::entry_t      rd_entry,
	output logic                    rd_vld
);
	import arttbl_pkg::*;

	entry_t                   mem_q [TABLE_ENTRIES];
	entry_t                   rd_entry_q;
	logic [TABLE_ENTRIES-1:0] vld_q;
	logic                     rd_vld_q;

	// Entry memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (ctl.mem_we) begin
			mem_q[wr_idx] <= wr_entry;
		end
		if (ctl.rd_en) begin
			rd_entry_q <= mem_q[rd_idx];
		end
	end

	// Valid bits live in flip-flops so that reset empties the table at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctl.vld_set) begin
				vld_q[wr_idx] <= 1'b1;
			end else if (ctl.vld_clr) begin
				vld_q[wr_idx] <= 1'b0;
			end
			if (ctl.rd_en) begin
				rd_vld_q <= vld_q[rd_idx];
			end
		end
	end

	assign rd_entry = rd_entry_q;
	assign rd_vld   = rd_vld_q;
endmodule

`default_nettype wire

// File: src/address_range_translation_table.sv
// Range translation table: holds up to TABLE_ENTRIES host ranges (start, size,
// device address) and serves one request at a time on the req channel.
// A request carries mode (lookup, set, clear or none), host_address, buffer_size and
// device_va. Each request gives exactly one result on the rsp channel: status,
// translated_address, exact_key and the entry count after the request.
// Both channels use valid/ready; a transfer happens when both are high.
// A request costs a full scan of the entry memory, one entry per cycle through
// its single read port, then four steps on the shared adder and comparator.
// req.ready is high only while the block is idle. A stalled result is held
// stable in the output register until rsp.ready is seen; no new request is
// taken meanwhile.
// Reset clears every valid bit and the entry count at once; the block is
// ready as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none
`include "address_range_translation_table_assert.svh"

module address_range_translation_table #(
	parameter int TABLE_ENTRIES = arttbl_pkg::TABLE_ENTRIES_DEF
) (
	input wire           clk,
	input wire           arst_n,
	arttbl_req_if.sink   req,
	arttbl_rsp_if.source rsp
);
	import arttbl_pkg::*;

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	state_t            state_q, state_d;
	logic [IW-1:0]     rd_idx_q;
	logic              cmp_vld_s1;
	logic [IW-1:0]     cmp_idx_s1;

	// Captured request.
	mode_t             mode_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] size_q;
	logic [ADDR_W-1:0] va_q;
	logic [ADDR_W-1:0] sz_eff;

	// Search results.
	entry_t            best_q;
	logic [IW-1:0]     best_idx_q;
	logic              exact_found_q;
	logic              pred_found_q;
	logic              free_found_q;
	logic [IW-1:0]     free_idx_q;

	// Range check intermediates.
	logic [ADDR_W-1:0] elast_q;
	logic [ADDR_W-1:0] rlast_q;
	logic [ADDR_W-1:0] off_q;
	logic              tgt_eq_q;
	logic              sz_gt_len_q;
	logic              len_eq_q;
	logic              a_gt_e_q;
	logic              r_le_e_q;
	logic              a_lt_b_q;

	logic [CW-1:0]     cnt_q, cnt_d;
	result_t           res_q, res_d;
	status_t           srch;

	// Shared unit and store connections.
	alu_op_t           alu_op;
	logic [ADDR_W-1:0] add_a, add_b, cmp_a, cmp_b, cmp_c, cmp_d;
	alu_res_t          alu;
	store_ctl_t        st_ctl;
	logic [IW-1:0]     wr_idx;
	entry_t            wr_entry;
	entry_t            rd_entry;
	logic              rd_vld;
	logic              in_ready;
	logic              out_valid;
	logic              accept;
	logic              scan_hit, scan_pred, scan_free;

	arttbl_alu u_alu (
		.op    (alu_op),
		.add_a (add_a),
		.add_b (add_b),
		.cmp_a (cmp_a),
		.cmp_b (cmp_b),
		.cmp_c (cmp_c),
		.cmp_d (cmp_d),
		.res   (alu)
	);

	arttbl_store #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (st_ctl),
		.rd_idx   (rd_idx_q),
		.wr_idx   (wr_idx),
		.wr_entry (wr_entry),
		.rd_entry (rd_entry),
		.rd_vld   (rd_vld)
	);

	assign accept   = req.valid && in_ready;
	assign sz_eff   = (mode_q == MODE_CLEAR) ? ADDR_W'(1) : size_q;
	assign wr_entry = '{base: addr_q, len: size_q, tgt: va_q};

	// Scan step: exact start match wins; else track the greatest start below
	// the address, earliest slot on ties; also note the lowest free slot.
	assign scan_hit  = cmp_vld_s1 && rd_vld && !exact_found_q && alu.eq;
	assign scan_pred = cmp_vld_s1 && rd_vld && !exact_found_q && alu.lt
		&& (!pred_found_q || alu.lt2);
	assign scan_free = cmp_vld_s1 && !rd_vld && !free_found_q;

	// Outcome of the search once the range checks are in.
	always_comb begin
		priority if (exact_found_q) begin
			srch = sz_gt_len_q ? ST_INVALID_SIZE : ST_OK;
		end else if (!pred_found_q || a_gt_e_q || a_lt_b_q) begin
			srch = ST_NOT_FOUND;
		end else begin
			srch = r_le_e_q ? ST_OK : ST_INVALID_SIZE;
		end
	end

	// Sequencer: next state, operand selection and the final decision.
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		alu_op    = ALU_ADD;
		add_a     = '0;
		add_b     = '0;
		cmp_a     = '0;
		cmp_b     = '0;
		cmp_c     = '0;
		cmp_d     = '0;
		st_ctl    = '0;
		wr_idx    = best_idx_q;
		cnt_d     = cnt_q;
		res_d     = res_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (req.valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				st_ctl.rd_en = 1'b1;
				cmp_a = rd_entry.base;
				cmp_b = addr_q;
				cmp_c = best_q.base;
				cmp_d = rd_entry.base;
				if (rd_idx_q == IW'(TABLE_ENTRIES - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				cmp_a = rd_entry.base;
				cmp_b = addr_q;
				cmp_c = best_q.base;
				cmp_d = rd_entry.base;
				state_d = ST_EVAL1;
			end
			ST_EVAL1: begin
				// Entry end, target match, request longer than entry.
				alu_op = ALU_ADDM1;
				add_a = best_q.base;
				add_b = best_q.len;
				cmp_a = best_q.tgt;
				cmp_b = va_q;
				cmp_c = best_q.len;
				cmp_d = sz_eff;
				state_d = ST_EVAL2;
			end
			ST_EVAL2: begin
				// Request end, length match, address past entry end.
				alu_op = ALU_ADDM1;
				add_a = addr_q;
				add_b = sz_eff;
				cmp_a = best_q.len;
				cmp_b = sz_eff;
				cmp_c = elast_q;
				cmp_d = addr_q;
				state_d = ST_EVAL3;
			end
			ST_EVAL3: begin
				// Offset into entry, request end within entry, address below start.
				alu_op = ALU_SUB;
				add_a = addr_q;
				add_b = best_q.base;
				cmp_a = rlast_q;
				cmp_b = elast_q;
				cmp_c = addr_q;
				cmp_d = best_q.base;
				state_d = ST_EVAL4;
			end
			ST_EVAL4: begin
				alu_op = ALU_ADD;
				add_a = best_q.tgt;
				add_b = off_q;
				res_d.trans = '0;
				res_d.exact = 1'b0;
				unique case (mode_q)
					MODE_LOOKUP: begin
						res_d.status = srch;
						if (srch == ST_OK) begin
							res_d.trans = alu.sum;
							res_d.exact = exact_found_q;
						end
					end
					MODE_SET: begin
						if (srch == ST_NOT_FOUND) begin
							if (free_found_q) begin
								st_ctl.mem_we  = 1'b1;
								st_ctl.vld_set = 1'b1;
								wr_idx = free_idx_q;
								cnt_d = cnt_q + CW'(1);
								res_d.status = ST_OK;
							end else begin
								res_d.status = ST_FULL;
							end
						end else if (tgt_eq_q && len_eq_q) begin
							res_d.status = ST_OK;
						end else begin
							res_d.status = ST_CONFLICT;
						end
					end
					MODE_CLEAR: begin
						if (srch == ST_OK && exact_found_q) begin
							st_ctl.vld_clr = 1'b1;
							wr_idx = best_idx_q;
							if (cnt_q != '0) begin
								cnt_d = cnt_q - CW'(1);
							end
							res_d.status = ST_OK;
						end else begin
							res_d.status = ST_NOT_FOUND;
						end
					end
					MODE_NONE: begin
						res_d.status = ST_NOT_FOUND;
					end
				endcase
				state_d = ST_RESP;
			end
			ST_RESP: begin
				out_valid = 1'b1;
				if (rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			rd_idx_q      <= '0;
			cmp_vld_s1    <= 1'b0;
			exact_found_q <= 1'b0;
			pred_found_q  <= 1'b0;
			free_found_q  <= 1'b0;
			cnt_q         <= '0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= (state_q == ST_SCAN);
			cnt_q      <= cnt_d;
			if (accept) begin
				rd_idx_q      <= '0;
				exact_found_q <= 1'b0;
				pred_found_q  <= 1'b0;
				free_found_q  <= 1'b0;
			end else begin
				if (state_q == ST_SCAN && rd_idx_q != IW'(TABLE_ENTRIES - 1)) begin
					rd_idx_q <= rd_idx_q + IW'(1);
				end
				if (scan_hit) begin
					exact_found_q <= 1'b1;
				end
				if (scan_pred) begin
					pred_found_q <= 1'b1;
				end
				if (scan_free) begin
					free_found_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		cmp_idx_s1 <= rd_idx_q;
		if (accept) begin
			mode_q <= mode_t'(req.mode);
			addr_q <= req.host_address;
			size_q <= req.buffer_size;
			va_q   <= req.device_va;
		end
		if (scan_hit || scan_pred) begin
			best_q     <= rd_entry;
			best_idx_q <= cmp_idx_s1;
		end
		if (scan_free) begin
			free_idx_q <= cmp_idx_s1;
		end
		if (state_q == ST_EVAL1) begin
			elast_q     <= alu.sum;
			tgt_eq_q    <= alu.eq;
			sz_gt_len_q <= alu.lt2;
		end
		if (state_q == ST_EVAL2) begin
			rlast_q  <= alu.sum;
			len_eq_q <= alu.eq;
			a_gt_e_q <= alu.lt2;
		end
		if (state_q == ST_EVAL3) begin
			off_q    <= alu.sum;
			r_le_e_q <= alu.lt || alu.eq;
			a_lt_b_q <= alu.lt2;
		end
		if (state_q == ST_EVAL4) begin
			res_q <= res_d;
		end
	end

	// Channel outputs.
	assign req.ready              = in_ready;
	assign rsp.valid              = out_valid;
	assign rsp.status             = res_q.status;
	assign rsp.translated_address = res_q.trans;
	assign rsp.exact_key          = res_q.exact;
	assign rsp.entry_count        = COUNT_W'(cnt_q);

	// Checks on the sequencer and the entry count.
	`ARTTBL_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CW'(TABLE_ENTRIES), "entry count above table size")
	`ARTTBL_ASSERT_NXT(a_accept_scan, accept, state_q == ST_SCAN && rd_idx_q == '0, "scan did not start at slot zero")
	`ARTTBL_ASSERT_NXT(a_cnt_hold, state_q != ST_EVAL4, $stable(cnt_q), "entry count changed outside the decision step")
	`ARTTBL_ASSERT_IMP(a_full_cnt, out_valid && res_q.status == ST_FULL, cnt_q == CW'(TABLE_ENTRIES), "table full reported with free slots")
	`ARTTBL_ASSERT_IMP(a_exact_base, state_q == ST_EVAL1 && exact_found_q, best_q.base == addr_q, "exact hit with a different start")
endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import arttbl_pkg::*;

	localparam int SLOTS = TABLE_ENTRIES_DEF;
	localparam int LATENCY = SLOTS + 6;
	localparam int RANDOM_ITEMS = 2000;
	localparam int PHASE_LEN = 160;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int IDLE_PCT = 12;
	localparam int PRESSURE_AT = 300;
	localparam int PRESSURE_CYCLES = 400;
	localparam int STEADY_FROM = 1000;
	localparam int STEADY_TO = 1300;
	localparam int MAX_PRINTED = 100;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef enum int {
		PH_FILL,
		PH_MIXED,
		PH_DRAIN
	} phase_t;

	typedef struct packed {
		mode_t       mode;
		logic [63:0] addr;
		logic [63:0] size;
		logic [63:0] va;
	} request_t;

	typedef struct packed {
		status_t     status;
		logic [63:0] trans;
		logic        exact;
		logic [6:0]  count;
	} answer_t;

	typedef struct packed {
		request_t rq;
		logic     typed;
		answer_t  ans;
	} plan_row_t;

	localparam answer_t UNTYPED = '{ST_OK, 64'h0, 1'b0, 7'd0};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic hold_off = 1'b0;
	logic steady = 1'b0;

	arttbl_req_if req_ch ();
	arttbl_rsp_if rsp_ch ();

	// Mirror of the translation table.
	bit          tbl_valid [SLOTS];
	logic [63:0] tbl_base [SLOTS];
	logic [63:0] tbl_len [SLOTS];
	logic [63:0] tbl_tgt [SLOTS];
	logic [6:0]  tbl_count = 7'd0;

	answer_t   pending [$];
	plan_row_t plan [$];
	int        sent_cnt = 0;
	int        results_seen = 0;
	int        mismatches = 0;
	int        cycle_cnt = 0;

	address_range_translation_table #(
		.TABLE_ENTRIES(SLOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a run that hangs.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles, %0d results pending", cycle_cnt,
				pending.size());
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic report_error(input string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("ERROR @%0t result %0d: %s", $realtime, results_seen, msg);
	endtask

	// Range search: exact start first, otherwise the nearest start below addr.
	function automatic status_t find_range(input logic [63:0] addr,
		input logic [63:0] size, output int hit);
		int pred;
		logic [63:0] elast;
		logic [63:0] rlast;
		pred = -1;
		hit = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (!tbl_valid[i])
				continue;
			if (tbl_base[i] == addr) begin
				hit = i;
				return (size > tbl_len[i]) ? ST_INVALID_SIZE : ST_OK;
			end
			if (tbl_base[i] < addr && (pred < 0 || tbl_base[i] > tbl_base[pred]))
				pred = i;
		end
		if (pred < 0)
			return ST_NOT_FOUND;
		hit = pred;
		elast = tbl_base[pred] + tbl_len[pred] - 64'd1;
		rlast = addr + size - 64'd1;
		if (addr > elast || addr < tbl_base[pred])
			return ST_NOT_FOUND;
		return (rlast <= elast) ? ST_OK : ST_INVALID_SIZE;
	endfunction

	// Apply one request to the mirror and return the result it should give.
	function automatic answer_t translate_request(input request_t rq);
		answer_t ans;
		status_t st;
		int hit;
		ans = '{ST_NOT_FOUND, 64'h0, 1'b0, 7'd0};
		case (rq.mode)
			MODE_LOOKUP: begin
				st = find_range(rq.addr, rq.size, hit);
				ans.status = st;
				if (st == ST_OK && hit >= 0) begin
					ans.trans = tbl_tgt[hit] + (rq.addr - tbl_base[hit]);
					ans.exact = (tbl_base[hit] == rq.addr);
				end
			end
			MODE_SET: begin
				st = find_range(rq.addr, rq.size, hit);
				if (st == ST_NOT_FOUND) begin
					ans.status = ST_FULL;
					for (int i = 0; i < SLOTS; i++) begin
						if (!tbl_valid[i]) begin
							tbl_valid[i] = 1'b1;
							tbl_base[i] = rq.addr;
							tbl_len[i] = rq.size;
							tbl_tgt[i] = rq.va;
							tbl_count = tbl_count + 7'd1;
							ans.status = ST_OK;
							break;
						end
					end
				end else if (hit >= 0 && tbl_tgt[hit] == rq.va && tbl_len[hit] == rq.size) begin
					ans.status = ST_OK;
				end else begin
					ans.status = ST_CONFLICT;
				end
			end
			MODE_CLEAR: begin
				st = find_range(rq.addr, 64'd1, hit);
				if (st == ST_OK && hit >= 0 && tbl_base[hit] == rq.addr) begin
					tbl_valid[hit] = 1'b0;
					if (tbl_count != 7'd0)
						tbl_count = tbl_count - 7'd1;
					ans.status = ST_OK;
				end
			end
			default: begin
			end
		endcase
		ans.count = tbl_count;
		return ans;
	endfunction

	// Random request biased toward ranges that already exist or sit on a grid.
	function automatic request_t random_request(input phase_t kind,
		input logic [63:0] region);
		request_t rq;
		int r;
		int slot;
		int exact_pct;
		r = $urandom_range(0, 99);
		case (kind)
			PH_FILL:
				rq.mode = (r < 75) ? MODE_SET : (r < 90) ? MODE_LOOKUP :
					(r < 97) ? MODE_CLEAR : MODE_NONE;
			PH_DRAIN:
				rq.mode = (r < 55) ? MODE_CLEAR : (r < 80) ? MODE_LOOKUP :
					(r < 95) ? MODE_SET : MODE_NONE;
			default:
				rq.mode = (r < 35) ? MODE_SET : (r < 70) ? MODE_LOOKUP :
					(r < 95) ? MODE_CLEAR : MODE_NONE;
		endcase

		// Host address.
		slot = -1;
		exact_pct = (rq.mode == MODE_CLEAR) ? 70 : 30;
		r = $urandom_range(0, 99);
		if (tbl_count != 7'd0 && r < exact_pct + 15) begin
			slot = $urandom_range(0, SLOTS - 1);
			while (!tbl_valid[slot])
				slot = (slot + 1) % SLOTS;
			rq.addr = tbl_base[slot];
			if (r >= exact_pct)
				rq.addr = rq.addr + $urandom_range(1, 32'h1FF);
		end else if (r < 75) begin
			rq.addr = region + $urandom_range(0, 127) * 64'h100;
		end else if (r < 92) begin
			rq.addr = region + $urandom_range(0, 32'h7FFF);
		end else begin
			rq.addr = {$urandom, $urandom};
		end

		// Request size.
		r = $urandom_range(0, 99);
		if (r < 45)
			rq.size = $urandom_range(1, 32'h100);
		else if (r < 55)
			rq.size = 64'h0;
		else if (r < 65 && slot >= 0)
			rq.size = tbl_len[slot] + $urandom_range(0, 1);
		else if (r < 90)
			rq.size = $urandom_range(1, 32'h400);
		else
			rq.size = {$urandom, $urandom};

		rq.va = {$urandom, $urandom};

		// Identical remap of an existing entry.
		if (rq.mode == MODE_SET && slot >= 0 && rq.addr == tbl_base[slot] &&
			$urandom_range(0, 1) == 1) begin
			rq.size = tbl_len[slot];
			rq.va = tbl_tgt[slot];
		end
		return rq;
	endfunction

	// Offer one request, wait for its handshake and record its expected result.
	task automatic send_request(input request_t rq, input logic typed,
		input answer_t typed_ans);
		answer_t ans;
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode <= rq.mode;
		req_ch.host_address <= rq.addr;
		req_ch.buffer_size <= rq.size;
		req_ch.device_va <= rq.va;
		do
			@(posedge clk);
		while (!req_ch.ready);
		ans = translate_request(rq);
		pending.push_back(typed ? typed_ans : ans);
		sent_cnt++;
	endtask

	// Result side: random back-pressure and field-by-field checking.
	initial begin
		answer_t want;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				results_seen++;
				if (pending.size() == 0) begin
					report_error("result arrived with no request pending");
				end else begin
					want = pending.pop_front();
					if (rsp_ch.status !== want.status)
						report_error($sformatf("status is %0d, expected %0d",
							rsp_ch.status, want.status));
					if (rsp_ch.translated_address !== want.trans)
						report_error($sformatf("translated_address is %h, expected %h",
							rsp_ch.translated_address, want.trans));
					if (rsp_ch.exact_key !== want.exact)
						report_error($sformatf("exact_key is %b, expected %b",
							rsp_ch.exact_key, want.exact));
					if (rsp_ch.entry_count !== want.count)
						report_error($sformatf("entry_count is %0d, expected %0d",
							rsp_ch.entry_count, want.count));
				end
			end
			rsp_ch.ready <= arst_n && !hold_off &&
				(steady || $urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// One long hold-off on results so that the block backs up its input.
	initial begin
		wait (sent_cnt >= PRESSURE_AT);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (PRESSURE_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Request side: directed table, then random phases.
	initial begin
		phase_t kind;
		logic [63:0] region;

		req_ch.valid = 1'b0;
		req_ch.mode = MODE_LOOKUP;
		req_ch.host_address = 64'h0;
		req_ch.buffer_size = 64'h0;
		req_ch.device_va = 64'h0;

		// Empty table, then one range at 0x1000 of 0x100 bytes.
		plan.push_back('{'{MODE_LOOKUP, 64'h0, 64'h1, 64'h0}, 1'b1,
			'{ST_NOT_FOUND, 64'h0, 1'b0, 7'd0}});
		plan.push_back('{'{MODE_CLEAR, 64'h0, 64'h0, 64'h0}, 1'b1,
			'{ST_NOT_FOUND, 64'h0, 1'b0, 7'd0}});
		plan.push_back('{'{MODE_NONE, ALL_ONES, ALL_ONES, ALL_ONES}, 1'b1,
			'{ST_NOT_FOUND, 64'h0, 1'b0, 7'd0}});
		plan.push_back('{'{MODE_SET, 64'h1000, 64'h100, 64'h8000_0000}, 1'b1,
			'{ST_OK, 64'h0, 1'b0, 7'd1}});
		plan.push_back('{'{MODE_LOOKUP, 64'h1000, 64'h100, 64'h0}, 1'b1,
			'{ST_OK, 64'h8000_0000, 1'b1, 7'd1}});
		plan.push_back('{'{MODE_LOOKUP, 64'h1000, 64'h101, 64'h0}, 1'b1,
			'{ST_INVALID_SIZE, 64'h0, 1'b0, 7'd1}});
		plan.push_back('{'{MODE_LOOKUP, 64'h10FF, 64'h1, 64'h0}, 1'b1,
			'{ST_OK, 64'h8000_00FF, 1'b0, 7'd1}});
		plan.push_back('{'{MODE_LOOKUP, 64'h10FF, 64'h2, 64'h0}, 1'b1,
			'{ST_INVALID_SIZE, 64'h0, 1'b0, 7'd1}});
		plan.push_back('{'{MODE_LOOKUP, 64'h1100, 64'h1, 64'h0}, 1'b1,
			'{ST_NOT_FOUND, 64'h0, 1'b0, 7'd1}});
		plan.push_back('{'{MODE_LOOKUP, 64'h0FFF, 64'h1, 64'h0}, 1'b1,
			'{ST_NOT_FOUND, 64'h0, 1'b0, 7'd1}});
		// Identical remap is accepted, a different target conflicts.
		plan.push_back('{'{MODE_SET, 64'h1000, 64'h100, 64'h8000_0000}, 1'b1,
			'{ST_OK, 64'h0, 1'b0, 7'd1}});
		plan.push_back('{'{MODE_SET, 64'h1000, 64'h100, 64'h9000_0000}, 1'b1,
			'{ST_CONFLICT, 64'h0, 1'b0, 7'd1}});
		// Overlap inside an entry, top of the address space, zero length, wraparound.
		plan.push_back('{'{MODE_SET, 64'h1080, 64'h10, 64'h1234}, 1'b0, UNTYPED});
		plan.push_back('{'{MODE_SET, ALL_ONES, ALL_ONES, ALL_ONES}, 1'b0, UNTYPED});
		plan.push_back('{'{MODE_LOOKUP, ALL_ONES, ALL_ONES, 64'h0}, 1'b0, UNTYPED});
		plan.push_back('{'{MODE_SET, 64'h2000, 64'h0, 64'h5}, 1'b0, UNTYPED});
		plan.push_back('{'{MODE_LOOKUP, 64'h2000, 64'h0, 64'h0}, 1'b0, UNTYPED});
		plan.push_back('{'{MODE_CLEAR, 64'h2000, 64'h0, 64'h0}, 1'b0, UNTYPED});
		plan.push_back('{'{MODE_LOOKUP, 64'h2001, 64'h1, 64'h0}, 1'b0, UNTYPED});
		plan.push_back('{'{MODE_SET, 64'hFFFF_FFFF_FFFF_FF00, 64'h200, 64'h40}, 1'b0,
			UNTYPED});
		plan.push_back('{'{MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FF80, 64'h1, 64'h0}, 1'b0,
			UNTYPED});
		plan.push_back('{'{MODE_SET, 64'h0, 64'h10, 64'h0}, 1'b0, UNTYPED});
		// Removal, repeated removal, removal at the top of the address space.
		plan.push_back('{'{MODE_CLEAR, 64'h1000, 64'h0, 64'h0}, 1'b0, UNTYPED});
		plan.push_back('{'{MODE_CLEAR, 64'h1000, ALL_ONES, ALL_ONES}, 1'b0, UNTYPED});
		plan.push_back('{'{MODE_CLEAR, ALL_ONES, 64'h0, 64'h0}, 1'b0, UNTYPED});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_request(plan[i].rq, plan[i].typed, plan[i].ans);

		// Random phases that fill, mix and drain the table around a moving region.
		kind = PH_FILL;
		region = 64'h0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % PHASE_LEN == 0) begin
				case ((n / PHASE_LEN) % 3)
					0: kind = PH_FILL;
					1: kind = PH_MIXED;
					default: kind = PH_DRAIN;
				endcase
				case ($urandom_range(0, 3))
					0: region = 64'h0;
					1: region = 64'hFFFF_FFFF_FFFF_C000;
					2: region = 64'h8000_0000_0000_0000;
					default: region = {$urandom, $urandom} & ~64'hFFFF;
				endcase
			end
			steady <= (n >= STEADY_FROM && n < STEADY_TO);
			send_request(random_request(kind, region), 1'b0, UNTYPED);
		end
		req_ch.valid <= 1'b0;
		steady <= 1'b0;

		// Drain the outstanding results, then watch for strays.
		while (pending.size() != 0)
			@(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);

		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
